// ===== rtl/core/clc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

	localparam int LINE_LEN_DEF = 20;
	localparam int CFG_IDX_W = 2;

	// ascii codes the line parser looks for
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [7:0] HIGH_LIMIT_RST  = 8'd26;
	localparam logic [7:0] LOW_LIMIT_RST   = 8'd23;
	localparam logic [3:0] OPEN_LEVEL_RST  = 4'd8;
	localparam logic [3:0] CLOSE_LEVEL_RST = 4'd5;
	localparam logic [7:0] MOTOR_STEPS_RST = 8'd40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPEN_LEVEL  = 2'd0,
		REG_CLOSE_LEVEL = 2'd1,
		REG_MOTOR_STEPS = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_OUT      = 3'd1,
		CMD_SET_HIGH = 3'd2,
		CMD_SET_LOW  = 3'd3,
		CMD_UNKNOWN  = 3'd4
	} cmd_kind_t;

	typedef enum logic [1:0] {
		MOVE_NONE  = 2'd0,
		MOVE_OPEN  = 2'd1,
		MOVE_CLOSE = 2'd2
	} move_t;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_EOL   = 2'd1,
		OP_LIGHT = 2'd2
	} op_code_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_WALK   = 2'd1,
		BK_FINISH = 2'd2
	} bk_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic [3:0] light_level;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        command_kind;
		logic              relay_on;
		logic              curtain_up;
		logic [1:0]        move;
		logic [7:0]        move_steps;
		logic              beep;
		logic              manual_mode;
		logic signed [7:0] high_limit;
		logic signed [7:0] low_limit;
	} out_item_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] data;
	} op_t;

	// "OUT:" by position
	function automatic logic [7:0] out_key_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0:    c = CH_O;
			2'd1:    c = CH_U;
			2'd2:    c = CH_T;
			default: c = CH_COLON;
		endcase
		return c;
	endfunction

	// "SETTH:" or "SETTL:" by position
	function automatic logic [7:0] set_key_char(input logic [2:0] i, input logic high);
		logic [7:0] c;
		case (i)
			3'd0:    c = CH_S;
			3'd1:    c = CH_E;
			3'd2:    c = CH_T;
			3'd3:    c = CH_T;
			3'd4:    c = high ? CH_H : CH_L;
			default: c = CH_COLON;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ascii_command_line_controller.sv =====
// ascii command line controller
// in channel (in_valid / in_stall / in_data): one transaction per received
// byte or light tick; the front classifies it and parks it in a 2-entry queue
// out channel (out_valid / out_stall / out_data): exactly one result per input
// transaction, in order, held in an output register until taken
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
// index 0 open level, 1 close level, 2 motor steps; other indexes ignored
// a plain byte, a light tick or an empty line end is registered into the
// output register as the back takes it; the back, when idle, takes one such
// transaction a cycle while the output register is free or being taken
// a line end with n stored bytes walks the line store one byte per cycle over
// its single read port while the queue keeps taking input until it is full
// when the receiver stalls the result register holds, the back waits, and
// in_stall rises once the queue is full
// reset: empty line, curtain open, relay on, auto mode, limits 26 and 23,
// levels 8 and 5, 40 motor steps; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module ascii_command_line_controller #(
	parameter int LINE_LEN = clc_pkg::LINE_LEN_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  clc_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  wire                             out_stall,
	output clc_pkg::out_item_t              out_data,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [clc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [7:0]                       cfg_data
);

	logic         q_valid;
	logic         q_pop;
	clc_pkg::op_t q_op;

	clc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	clc_back #(
		.LINE_LEN (LINE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/clc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  clc_pkg::in_item_t   in_data,
	output logic                q_valid,
	output clc_pkg::op_t        q_op,
	input  wire                 q_pop
);

	clc_pkg::op_t op_new;
	clc_pkg::op_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push;

	// classify the incoming transaction
	always_comb begin
		if (in_data.kind) begin
			op_new.code = clc_pkg::OP_LIGHT;
			op_new.data = {4'd0, in_data.light_level};
		end else if (in_data.rx_byte == clc_pkg::CH_LF || in_data.rx_byte == clc_pkg::CH_CR) begin
			op_new.code = clc_pkg::OP_EOL;
			op_new.data = in_data.rx_byte;
		end else begin
			op_new.code = clc_pkg::OP_STORE;
			op_new.data = in_data.rx_byte;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/clc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module clc_back #(
	parameter int LINE_LEN = clc_pkg::LINE_LEN_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             q_valid,
	input  clc_pkg::op_t                    q_op,
	output logic                            q_pop,
	output logic                            out_valid,
	input  wire                             out_stall,
	output clc_pkg::out_item_t              out_data,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [clc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [7:0]                       cfg_data
);

	localparam int IDX_W = $clog2(LINE_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_LEN - 1);

	clc_pkg::bk_state_t state_q, state_d;

	logic [7:0]       mem [LINE_LEN];
	logic [IDX_W-1:0] wi_q;
	logic             curtain_q, relay_q, manual_q;
	logic [7:0]       upper_q, lower_q;
	logic [3:0]       open_lvl_q, close_lvl_q;
	logic [7:0]       steps_q;

	logic [IDX_W-1:0] rd_pos_q;
	logic [IDX_W-1:0] chk_pos_s1;
	logic             chk_vld_s1;
	logic [7:0]       rd_data_s1;

	logic       out_m_q, th_m_q, tl_m_q, c4_q, neg_q, parse_q;
	logic [7:0] acc_q;

	logic                out_valid_q;
	clc_pkg::out_item_t  out_data_q;

	logic       out_free, head_go, is_store, is_light, start_walk;
	logic       walk_issue, walk_done, finish_go, load_res;
	logic       is_digit;
	logic [3:0] digit;
	logic [7:0] acc_next, num;
	logic       hit_out, hit_th, hit_tl;
	logic [3:0] light;

	logic               n_cur, n_rel, n_man;
	logic [7:0]         n_up, n_lo;
	clc_pkg::cmd_kind_t r_cmd;
	clc_pkg::move_t     r_move;
	logic               r_beep;
	clc_pkg::out_item_t res;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign out_free   = !out_valid_q || !out_stall;
	assign head_go    = (state_q == clc_pkg::BK_IDLE) && q_valid && out_free;
	assign is_store   = head_go && (q_op.code == clc_pkg::OP_STORE);
	assign is_light   = head_go && (q_op.code == clc_pkg::OP_LIGHT);
	assign start_walk = head_go && (q_op.code == clc_pkg::OP_EOL) && (wi_q != '0);
	assign walk_issue = (state_q == clc_pkg::BK_WALK) && (rd_pos_q != wi_q);
	assign walk_done  = (state_q == clc_pkg::BK_WALK) && (rd_pos_q == wi_q) && !chk_vld_s1;
	assign finish_go  = (state_q == clc_pkg::BK_FINISH) && out_free;
	assign load_res   = (head_go && !start_walk) || finish_go;
	assign q_pop      = head_go;
	assign light      = q_op.data[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clc_pkg::BK_IDLE: begin
				if (start_walk) begin
					state_d = clc_pkg::BK_WALK;
				end
			end
			clc_pkg::BK_WALK: begin
				if (walk_done) begin
					state_d = clc_pkg::BK_FINISH;
				end
			end
			clc_pkg::BK_FINISH: begin
				if (finish_go) begin
					state_d = clc_pkg::BK_IDLE;
				end
			end
			default: state_d = clc_pkg::BK_IDLE;
		endcase
	end

	// line store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (is_store) begin
			mem[wi_q] <= q_op.data;
		end
		rd_data_s1 <= mem[rd_pos_q];
		chk_pos_s1 <= rd_pos_q;
	end

	// per-character parse step
	assign is_digit = (rd_data_s1 >= clc_pkg::CH_ZERO) && (rd_data_s1 <= clc_pkg::CH_NINE);
	assign digit    = 4'(rd_data_s1 - clc_pkg::CH_ZERO);
	assign acc_next = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + {4'd0, digit};

	// a hit also needs at least as many stored bytes as its prefix, so short lines fail
	assign hit_out = out_m_q && (wi_q >= IDX_W'(4));
	assign hit_th  = th_m_q && (wi_q >= IDX_W'(6));
	assign hit_tl  = tl_m_q && (wi_q >= IDX_W'(6));
	assign num     = neg_q ? 8'(8'd0 - acc_q) : acc_q;

	always_ff @(posedge clk) begin
		if (start_walk) begin
			out_m_q <= 1'b1;
			th_m_q  <= 1'b1;
			tl_m_q  <= 1'b1;
			c4_q    <= 1'b0;
			neg_q   <= 1'b0;
			parse_q <= 1'b1;
			acc_q   <= 8'd0;
		end else if (chk_vld_s1) begin
			if (chk_pos_s1 < IDX_W'(4)
				&& rd_data_s1 != clc_pkg::out_key_char(chk_pos_s1[1:0])) begin
				out_m_q <= 1'b0;
			end
			if (chk_pos_s1 < IDX_W'(6)) begin
				if (rd_data_s1 != clc_pkg::set_key_char(chk_pos_s1[2:0], 1'b1)) begin
					th_m_q <= 1'b0;
				end
				if (rd_data_s1 != clc_pkg::set_key_char(chk_pos_s1[2:0], 1'b0)) begin
					tl_m_q <= 1'b0;
				end
			end
			if (chk_pos_s1 == IDX_W'(4)) begin
				c4_q <= (rd_data_s1 == clc_pkg::CH_ONE);
			end
			if (chk_pos_s1 == IDX_W'(6)) begin
				if (rd_data_s1 == clc_pkg::CH_MINUS) begin
					neg_q <= 1'b1;
				end else if (is_digit) begin
					acc_q <= {4'd0, digit};
				end else begin
					parse_q <= 1'b0;
				end
			end else if (chk_pos_s1 > IDX_W'(6) && parse_q) begin
				if (is_digit) begin
					acc_q <= acc_next;
				end else begin
					parse_q <= 1'b0;
				end
			end
		end
	end

	// state updates and the result of the transaction being finished
	always_comb begin
		n_cur  = curtain_q;
		n_rel  = relay_q;
		n_man  = manual_q;
		n_up   = upper_q;
		n_lo   = lower_q;
		r_cmd  = clc_pkg::CMD_NONE;
		r_move = clc_pkg::MOVE_NONE;
		r_beep = 1'b0;
		if (is_light && !manual_q) begin
			if (light >= open_lvl_q && !curtain_q) begin
				n_cur  = 1'b1;
				n_rel  = 1'b1;
				r_move = clc_pkg::MOVE_OPEN;
				r_beep = 1'b1;
			end else if (light <= close_lvl_q && curtain_q) begin
				n_cur  = 1'b0;
				n_rel  = 1'b0;
				r_move = clc_pkg::MOVE_CLOSE;
				r_beep = 1'b1;
			end
		end
		if (finish_go) begin
			if (hit_out) begin
				r_cmd  = clc_pkg::CMD_OUT;
				n_man  = 1'b1;
				n_rel  = c4_q;
				r_beep = 1'b1;
				if (c4_q && !curtain_q) begin
					n_cur  = 1'b1;
					r_move = clc_pkg::MOVE_OPEN;
				end else if (!c4_q && curtain_q) begin
					n_cur  = 1'b0;
					r_move = clc_pkg::MOVE_CLOSE;
				end
			end else if (hit_th) begin
				r_cmd  = clc_pkg::CMD_SET_HIGH;
				n_up   = num;
				n_man  = 1'b0;
				r_beep = 1'b1;
			end else if (hit_tl) begin
				r_cmd  = clc_pkg::CMD_SET_LOW;
				n_lo   = num;
				n_man  = 1'b0;
				r_beep = 1'b1;
			end else begin
				r_cmd = clc_pkg::CMD_UNKNOWN;
			end
		end
		res.command_kind = r_cmd;
		res.relay_on     = n_rel;
		res.curtain_up   = n_cur;
		res.move         = r_move;
		res.move_steps   = (r_move != clc_pkg::MOVE_NONE) ? steps_q : 8'd0;
		res.beep         = r_beep;
		res.manual_mode  = n_man;
		res.high_limit   = n_up;
		res.low_limit    = n_lo;
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q        <= '0;
			rd_pos_q    <= '0;
			chk_vld_s1  <= 1'b0;
			curtain_q   <= 1'b1;
			relay_q     <= 1'b1;
			manual_q    <= 1'b0;
			upper_q     <= clc_pkg::HIGH_LIMIT_RST;
			lower_q     <= clc_pkg::LOW_LIMIT_RST;
			open_lvl_q  <= clc_pkg::OPEN_LEVEL_RST;
			close_lvl_q <= clc_pkg::CLOSE_LEVEL_RST;
			steps_q     <= clc_pkg::MOTOR_STEPS_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (is_store) begin
				wi_q <= (wi_q == LAST_IDX) ? '0 : wi_q + 1'b1;
			end else if (finish_go) begin
				wi_q <= '0;
			end
			if (start_walk) begin
				rd_pos_q <= '0;
			end else if (walk_issue) begin
				rd_pos_q <= rd_pos_q + 1'b1;
			end
			chk_vld_s1 <= walk_issue;
			curtain_q  <= n_cur;
			relay_q    <= n_rel;
			manual_q   <= n_man;
			upper_q    <= n_up;
			lower_q    <= n_lo;
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					clc_pkg::REG_OPEN_LEVEL:  open_lvl_q  <= cfg_data[3:0];
					clc_pkg::REG_CLOSE_LEVEL: close_lvl_q <= cfg_data[3:0];
					clc_pkg::REG_MOTOR_STEPS: steps_q     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire
